FILE: rtl/gtp_pkg.sv
`default_nettype none
package gtp_pkg;

  localparam int unsigned HDG_W      = 9;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned RAD_W      = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ATAN_CELLS = 44;
  localparam int unsigned K_W        = 6;

  localparam logic [CFG_IDX_W-1:0] REG_HEADING_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_RAD = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;
  localparam logic [RAD_W-1:0] RAD_RESET = 16'd20;

  localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd180;

  typedef enum logic [1:0] {
    ACT_STOP  = 2'd0,
    ACT_FWD   = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } action_e;

  // Control that travels alongside the operands through the arctangent row.
  typedef struct packed {
    logic [HDG_W-1:0] base;
    logic             use_atan;
    logic             rev;
    logic             eqv;
    logic             far;
    logic [HDG_W-1:0] cur;
    logic [HDG_W-1:0] fin;
  } side_t;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  // Restoring long division, used only while the angle tables are built.
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sine and cosine of whole degrees in Q2.62, from a truncated Taylor series.
  // Evaluated only at elaboration.
  function automatic logic [63:0] sin_q62(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] dv;
    logic        done;
    x    = STEP_Q62 * 64'(k);
    x2   = mul_q62(x, x);
    term = x;
    s    = x;
    done = 1'b0;
    for (int n = 1; n < 40; n++) begin
      if (!done) begin
        dv   = 64'((2 * n) * (2 * n + 1));
        term = udiv64(mul_q62(term, x2), dv);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] cos_q62(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] dv;
    logic        done;
    x    = STEP_Q62 * 64'(k);
    x2   = mul_q62(x, x);
    term = Q62_ONE;
    c    = Q62_ONE;
    done = 1'b0;
    for (int n = 1; n < 40; n++) begin
      if (!done) begin
        dv   = 64'((2 * n - 1) * (2 * n));
        term = udiv64(mul_q62(term, x2), dv);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          c = c - term;
        end else begin
          c = c + term;
        end
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gtp_in_if.sv
`default_nettype none
interface gtp_in_if #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DUTY_BITS  = 8
);
  logic                         valid;
  logic                         ready;
  logic [COORD_BITS-1:0]        goal_x;
  logic [COORD_BITS-1:0]        goal_y;
  logic [COORD_BITS-1:0]        pose_x;
  logic [COORD_BITS-1:0]        pose_y;
  logic [gtp_pkg::HDG_W-1:0]    pose_heading;
  logic [gtp_pkg::HDG_W-1:0]    final_heading;
  logic [DUTY_BITS-1:0]         drive_speed;

  modport source (
    output valid, goal_x, goal_y, pose_x, pose_y, pose_heading, final_heading, drive_speed,
    input  ready
  );
  modport sink (
    input  valid, goal_x, goal_y, pose_x, pose_y, pose_heading, final_heading, drive_speed,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/gtp_out_if.sv
`default_nettype none
interface gtp_out_if #(
  parameter int unsigned DUTY_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic                      arrived;
  logic [gtp_pkg::HDG_W-1:0] bearing;
  logic [DUTY_BITS-1:0]      duty_front_left_fwd;
  logic [DUTY_BITS-1:0]      duty_front_left_rev;
  logic [DUTY_BITS-1:0]      duty_front_right_fwd;
  logic [DUTY_BITS-1:0]      duty_front_right_rev;
  logic [DUTY_BITS-1:0]      duty_rear_left_fwd;
  logic [DUTY_BITS-1:0]      duty_rear_left_rev;
  logic [DUTY_BITS-1:0]      duty_rear_right_fwd;
  logic [DUTY_BITS-1:0]      duty_rear_right_rev;

  modport source (
    output valid, action, arrived, bearing,
           duty_front_left_fwd, duty_front_left_rev, duty_front_right_fwd, duty_front_right_rev,
           duty_rear_left_fwd, duty_rear_left_rev, duty_rear_right_fwd, duty_rear_right_rev,
    input  ready
  );
  modport sink (
    input  valid, action, arrived, bearing,
           duty_front_left_fwd, duty_front_left_rev, duty_front_right_fwd, duty_front_right_rev,
           duty_rear_left_fwd, duty_rear_left_rev, duty_rear_right_fwd, duty_rear_right_rev,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/gtp_front.sv
`default_nettype none
module gtp_front #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DUTY_BITS  = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  gtp_in_if.sink                              in_i,
  input  wire logic [gtp_pkg::RAD_W-1:0]      radius_i,
  output logic                                valid_o,
  output logic [COORD_BITS-1:0]               num_o,
  output logic [COORD_BITS-1:0]               den_o,
  output gtp_pkg::side_t                      side_o,
  output logic [DUTY_BITS-1:0]                spd_o
);
  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned SQ_W  = (2 * CW + 1 > 33) ? 2 * CW + 1 : 33;

  assign in_i.ready = en_i;

  // Stage 1: differences, magnitudes and signs.
  logic                      v1_q;
  logic [CW-1:0]             ax_q, ay_q;
  logic                      nx_q, ny_q, zx_q, zy_q;
  logic [gtp_pkg::HDG_W-1:0] cur1_q, fin1_q;
  logic [DUTY_BITS-1:0]      spd1_q;
  logic [CW:0]               dx, dy;
  logic [CW:0]               adx, ady;

  always_comb begin
    dx  = {1'b0, in_i.goal_x} - {1'b0, in_i.pose_x};
    dy  = {1'b0, in_i.goal_y} - {1'b0, in_i.pose_y};
    adx = dx[CW] ? (~dx + 1'b1) : dx;
    ady = dy[CW] ? (~dy + 1'b1) : dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= adx[CW-1:0];
      ay_q   <= ady[CW-1:0];
      nx_q   <= dx[CW];
      ny_q   <= dy[CW];
      zx_q   <= (dx == '0);
      zy_q   <= (dy == '0);
      cur1_q <= in_i.pose_heading;
      fin1_q <= in_i.final_heading;
      spd1_q <= in_i.drive_speed;
    end
  end

  // Stage 2: squares, quadrant decode and operand ordering for the arctangent.
  logic                 v2_q;
  logic [2*CW-1:0]      sqx_q, sqy_q;
  logic [31:0]          rad2_q;
  logic                 nz2_q;
  logic [CW-1:0]        num2_q, den2_q;
  gtp_pkg::side_t       side2_q;
  logic [DUTY_BITS-1:0] spd2_q;
  logic                 px, py;
  logic [CW-1:0]        num_sel, den_sel;
  gtp_pkg::side_t       side_d;

  always_comb begin
    px      = !nx_q && !zx_q;
    py      = !ny_q && !zy_q;
    num_sel = ax_q;
    den_sel = ay_q;
    side_d  = '0;
    side_d.cur = cur1_q;
    side_d.fin = fin1_q;
    priority if (nx_q && ny_q) begin
      side_d.base = 9'd270; side_d.use_atan = 1'b1; num_sel = ay_q; den_sel = ax_q;
    end else if (px && py) begin
      side_d.base = 9'd90;  side_d.use_atan = 1'b1; num_sel = ay_q; den_sel = ax_q;
    end else if (px && ny_q) begin
      side_d.base = 9'd0;   side_d.use_atan = 1'b1;
    end else if (nx_q && py) begin
      side_d.base = 9'd180; side_d.use_atan = 1'b1;
    end else if (zx_q && py) begin
      side_d.base = 9'd180;
    end else if (zy_q && nx_q) begin
      side_d.base = 9'd270;
    end else if (zy_q && px) begin
      side_d.base = 9'd90;
    end else begin
      side_d.base = 9'd0;
    end
    side_d.rev = (num_sel > den_sel);
    side_d.eqv = (num_sel == den_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= (2*CW)'(ax_q) * (2*CW)'(ax_q);
      sqy_q   <= (2*CW)'(ay_q) * (2*CW)'(ay_q);
      rad2_q  <= 32'(radius_i) * 32'(radius_i);
      nz2_q   <= !(zx_q && zy_q);
      num2_q  <= side_d.rev ? den_sel : num_sel;
      den2_q  <= side_d.rev ? num_sel : den_sel;
      side2_q <= side_d;
      spd2_q  <= spd1_q;
    end
  end

  // Stage 3: range compare.
  logic [SQ_W-1:0] dist2;
  gtp_pkg::side_t  side3_d;

  always_comb begin
    dist2       = SQ_W'(sqx_q) + SQ_W'(sqy_q);
    side3_d     = side2_q;
    side3_d.far = nz2_q && (dist2 >= SQ_W'(rad2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num2_q;
      den_o  <= den2_q;
      side_o <= side3_d;
      spd_o  <= spd2_q;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gtp_atan_cell.sv
`default_nettype none
module gtp_atan_cell #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DUTY_BITS  = 8,
  parameter int unsigned J          = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [COORD_BITS-1:0]     num_i,
  input  wire logic [COORD_BITS-1:0]     den_i,
  input  wire logic [gtp_pkg::K_W-1:0]   k_i,
  input  wire gtp_pkg::side_t            side_i,
  input  wire logic [DUTY_BITS-1:0]      spd_i,
  output logic                           valid_o,
  output logic [COORD_BITS-1:0]          num_o,
  output logic [COORD_BITS-1:0]          den_o,
  output logic [gtp_pkg::K_W-1:0]        k_o,
  output gtp_pkg::side_t                 side_o,
  output logic [DUTY_BITS-1:0]           spd_o
);
  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned PW  = CW + 32;
  localparam int unsigned FW  = CW + 64;
  localparam logic [63:0] SIN_C = gtp_pkg::sin_q62(J + 1);
  localparam logic [63:0] COS_C = gtp_pkg::cos_q62(J + 1);
  localparam logic [gtp_pkg::K_W-1:0] K_HERE = gtp_pkg::K_W'(J);

  // Stage A: partial products of both sides of den*sin <= num*cos.
  logic                     va_q;
  logic [CW-1:0]            num_a_q, den_a_q;
  logic [gtp_pkg::K_W-1:0]  k_a_q;
  gtp_pkg::side_t           side_a_q;
  logic [DUTY_BITS-1:0]     spd_a_q;
  logic [PW-1:0]            ps_hi_q, ps_lo_q, pc_hi_q, pc_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q  <= num_i;
      den_a_q  <= den_i;
      k_a_q    <= k_i;
      side_a_q <= side_i;
      spd_a_q  <= spd_i;
      ps_hi_q  <= PW'(den_i) * PW'(SIN_C[63:32]);
      ps_lo_q  <= PW'(den_i) * PW'(SIN_C[31:0]);
      pc_hi_q  <= PW'(num_i) * PW'(COS_C[63:32]);
      pc_lo_q  <= PW'(num_i) * PW'(COS_C[31:0]);
    end
  end

  // Stage B: full compare; the count only advances while every earlier step passed.
  logic [FW-1:0] lhs, rhs;
  logic          pass;

  always_comb begin
    lhs  = {ps_hi_q, 32'b0} + FW'(ps_lo_q);
    rhs  = {pc_hi_q, 32'b0} + FW'(pc_lo_q);
    pass = (k_a_q == K_HERE) && (lhs <= rhs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_a_q;
      den_o  <= den_a_q;
      k_o    <= pass ? k_a_q + 1'b1 : k_a_q;
      side_o <= side_a_q;
      spd_o  <= spd_a_q;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gtp_back.sv
`default_nettype none
module gtp_back #(
  parameter int unsigned DUTY_BITS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [gtp_pkg::K_W-1:0]   k_i,
  input  wire gtp_pkg::side_t            side_i,
  input  wire logic [DUTY_BITS-1:0]      spd_i,
  input  wire logic [gtp_pkg::TOL_W-1:0] tol_i,
  output logic                           en_o,
  gtp_out_if.source                      out_o
);
  localparam int unsigned HW = gtp_pkg::HDG_W;

  logic                    out_valid_q;
  logic [6:0]              atan_deg;
  logic [HW-1:0]           bearing;
  logic [HW-1:0]           want;
  logic                    wrap;
  logic signed [HW:0]      diff;
  logic [HW:0]             mag;
  gtp_pkg::action_e        turn;
  gtp_pkg::action_e        act;
  logic                    arr;
  logic [DUTY_BITS-1:0]    duty [8];

  assign en_o = !out_valid_q || out_o.ready;

  always_comb begin
    if (side_i.eqv) begin
      atan_deg = 7'd45;
    end else if (side_i.rev) begin
      atan_deg = 7'd89 - 7'(k_i);
    end else begin
      atan_deg = 7'(k_i);
    end
    bearing = side_i.base + (side_i.use_atan ? HW'(atan_deg) : '0);
    want    = side_i.far ? bearing : side_i.fin;

    // Headings either side of north within a few degrees count as aligned.
    wrap = (side_i.cur >= 9'd355 && side_i.cur <= 9'd360 && want <= 9'd5) ||
           (want >= 9'd355 && want <= 9'd360 && side_i.cur <= 9'd5);
    diff = $signed({1'b0, side_i.cur}) - $signed({1'b0, want});
    mag  = diff[HW] ? (HW+1)'(-diff) : (HW+1)'(diff);

    if (wrap || diff == '0 || mag < (HW+1)'(tol_i)) begin
      turn = gtp_pkg::ACT_STOP;
    end else if (diff[HW]) begin
      turn = (mag >= (HW+1)'(180)) ? gtp_pkg::ACT_LEFT : gtp_pkg::ACT_RIGHT;
    end else begin
      turn = (mag >= (HW+1)'(180)) ? gtp_pkg::ACT_RIGHT : gtp_pkg::ACT_LEFT;
    end

    arr = 1'b0;
    if (side_i.far) begin
      act = (turn == gtp_pkg::ACT_STOP) ? gtp_pkg::ACT_FWD : turn;
    end else begin
      act = turn;
      arr = (turn == gtp_pkg::ACT_STOP);
    end

    for (int i = 0; i < 8; i++) begin
      duty[i] = '0;
    end
    unique case (act)
      gtp_pkg::ACT_FWD: begin
        duty[0] = spd_i; duty[2] = spd_i; duty[4] = spd_i; duty[6] = spd_i;
      end
      gtp_pkg::ACT_LEFT: begin
        duty[1] = spd_i; duty[2] = spd_i; duty[5] = spd_i; duty[6] = spd_i;
      end
      gtp_pkg::ACT_RIGHT: begin
        duty[0] = spd_i; duty[3] = spd_i; duty[4] = spd_i; duty[7] = spd_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_o.action               <= act;
      out_o.arrived              <= arr;
      out_o.bearing              <= bearing;
      out_o.duty_front_left_fwd  <= duty[0];
      out_o.duty_front_left_rev  <= duty[1];
      out_o.duty_front_right_fwd <= duty[2];
      out_o.duty_front_right_rev <= duty[3];
      out_o.duty_rear_left_fwd   <= duty[4];
      out_o.duty_rear_left_rev   <= duty[5];
      out_o.duty_rear_right_fwd  <= duty[6];
      out_o.duty_rear_right_rev  <= duty[7];
    end
  end

  assign out_o.valid = out_valid_q;

  a_arrived_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.arrived |-> out_o.action == gtp_pkg::ACT_STOP)
    else $error("arrival flagged with a moving action");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_o.bearing < 9'd360)
    else $error("bearing out of range");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.action == gtp_pkg::ACT_STOP |->
      out_o.duty_front_left_fwd == '0 && out_o.duty_front_right_fwd == '0 &&
      out_o.duty_rear_left_fwd == '0 && out_o.duty_rear_right_fwd == '0)
    else $error("wheel driven while stopped");
endmodule
`default_nettype wire

FILE: rtl/go_to_point_heading_steer.sv
`default_nettype none
// Steering decision per pose beat: bearing to the goal, range test against the arrival
// radius and the resulting action with eight mecanum wheel duties. One beat is accepted
// every cycle and each result passes through 92 register stages (three front stages, 44
// arctangent cells of two stages each, one output register); the row of arctangent
// cells resolves one whole degree per cell. The input stalls only while a finished
// result waits to be taken. Configuration writes take effect on the next beat and must
// be issued while the block is empty.
module go_to_point_heading_steer #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DUTY_BITS  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gtp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gtp_pkg::CFG_W-1:0]     cfg_data_i,
  gtp_in_if.sink                             in_i,
  gtp_out_if.source                          out_o
);
  localparam int unsigned N = gtp_pkg::ATAN_CELLS;

  logic [gtp_pkg::TOL_W-1:0] tol_q;
  logic [gtp_pkg::RAD_W-1:0] radius_q;
  logic                      en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= gtp_pkg::TOL_RESET;
      radius_q <= gtp_pkg::RAD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gtp_pkg::REG_HEADING_TOL: tol_q    <= cfg_data_i[gtp_pkg::TOL_W-1:0];
        gtp_pkg::REG_ARRIVAL_RAD: radius_q <= cfg_data_i[gtp_pkg::RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic                    v_c    [N+1];
  logic [COORD_BITS-1:0]   num_c  [N+1];
  logic [COORD_BITS-1:0]   den_c  [N+1];
  logic [gtp_pkg::K_W-1:0] k_c    [N+1];
  gtp_pkg::side_t          side_c [N+1];
  logic [DUTY_BITS-1:0]    spd_c  [N+1];

  gtp_front #(
    .COORD_BITS (COORD_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .in_i     (in_i),
    .radius_i (radius_q),
    .valid_o  (v_c[0]),
    .num_o    (num_c[0]),
    .den_o    (den_c[0]),
    .side_o   (side_c[0]),
    .spd_o    (spd_c[0])
  );

  assign k_c[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_cell
    gtp_atan_cell #(
      .COORD_BITS (COORD_BITS),
      .DUTY_BITS  (DUTY_BITS),
      .J          (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_c[j]),
      .num_i   (num_c[j]),
      .den_i   (den_c[j]),
      .k_i     (k_c[j]),
      .side_i  (side_c[j]),
      .spd_i   (spd_c[j]),
      .valid_o (v_c[j+1]),
      .num_o   (num_c[j+1]),
      .den_o   (den_c[j+1]),
      .k_o     (k_c[j+1]),
      .side_o  (side_c[j+1]),
      .spd_o   (spd_c[j+1])
    );
  end

  gtp_back #(
    .DUTY_BITS (DUTY_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_c[N]),
    .k_i     (k_c[N]),
    .side_i  (side_c[N]),
    .spd_i   (spd_c[N]),
    .tol_i   (tol_q),
    .en_o    (en),
    .out_o   (out_o)
  );
endmodule
`default_nettype wire
